FILE: rtl/ptbs_pkg.sv
// ----------------------------------------------------------------------------
// ptbs_pkg
// Shared constants and controller/datapath types for the touched block set.
// ----------------------------------------------------------------------------
package ptbs_pkg;

  localparam int unsigned CAPACITY_DEF = 4096;
  localparam int unsigned MAX_SPAN_DEF = 4;

  localparam logic [31:0] HASH_P0 = 32'd73856093;
  localparam logic [31:0] HASH_P1 = 32'd19349669;
  localparam logic [31:0] HASH_P2 = 32'd83492791;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_VOXEL_EDGE = 2'd0;
  localparam logic [1:0] REG_RESOLUTION = 2'd1;
  localparam logic [1:0] REG_TRUNC_DIST = 2'd2;

  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int unsigned VOXEL_W = 25;
  localparam int unsigned RES_W   = 7;
  localparam int unsigned TRUNC_W = 25;
  localparam int unsigned CFG_W   = 25;
  localparam int unsigned STORED_W = 13;

  // Divider: 35-bit dividend magnitude, 32-bit divisor
  localparam int unsigned DIV_NW = 35;
  localparam int unsigned DIV_DW = 32;
  localparam int unsigned DIV_CW = 6;

  localparam logic [1:0] STEP_X = 2'd0;
  localparam logic [1:0] STEP_Y = 2'd1;
  localparam logic [1:0] STEP_Z = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic       clear_start;
    logic       div_prep;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_axis;
    logic       div_hi;
    logic       span_calc;
    logic       hash_en;
    logic [1:0] hash_step;
    logic       probe_init;
    logic       mem_read;
    logic       probe_check;
    logic       out_load;
    logic       out_clear;
    logic       next_block;
    logic       sweep_step;
  } ptbs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic probe_done;
    logic last_block;
    logic sweep_done;
    logic out_free;
  } ptbs_status_t;

endpackage

FILE: rtl/ptbs_div.sv
// ----------------------------------------------------------------------------
// ptbs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptbs_div
  import ptbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o
);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] quot_q, quot_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, quot_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (run_q) begin
      quot_d = {quot_q[DIV_NW-2:0], fits};
      rem_d  = fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/ptbs_dp.sv
// ----------------------------------------------------------------------------
// ptbs_dp
// Datapath: configuration, block range, hash, set memory and result register.
// ----------------------------------------------------------------------------
module ptbs_dp
  import ptbs_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  ptbs_cmd_t           cmd_i,
  output ptbs_status_t        status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  block_x_o,
  output logic signed [31:0]  block_y_o,
  output logic signed [31:0]  block_z_o,
  output logic                first_touch_o,
  output logic                set_full_o,
  output logic                span_clipped_o,
  output logic [STORED_W-1:0] stored_blocks_o,
  output logic                last_of_item_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = ($clog2(CAPACITY + 1) > STORED_W) ?
                                  $clog2(CAPACITY + 1) : STORED_W;
  localparam int unsigned CW    = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int unsigned ROW_W = 97;

  // Configuration
  logic [VOXEL_W-1:0] voxel_q;
  logic [RES_W-1:0]   res_q;
  logic [TRUNC_W-1:0] trunc_q;
  logic [31:0]        bs_prod;
  logic [31:0]        bs_q;
  logic [31:0]        bsm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voxel_q <= VOXEL_W'(384);
      res_q   <= RES_W'(16);
      trunc_q <= TRUNC_W'(2621);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VOXEL_EDGE: voxel_q <= cfg_wdata_i[VOXEL_W-1:0];
        REG_RESOLUTION: res_q   <= cfg_wdata_i[RES_W-1:0];
        REG_TRUNC_DIST: trunc_q <= cfg_wdata_i[TRUNC_W-1:0];
        default: ;
      endcase
    end
  end

  assign bs_prod = {7'b0, voxel_q} * {25'b0, res_q};

  always_ff @(posedge clk_i) begin
    bs_q   <= (bs_prod == '0) ? 32'd1 : bs_prod;
    bsm1_q <= bs_q - 32'd1;
  end

  // Per-axis range
  logic signed [31:0] p_q   [3];
  logic signed [31:0] lo_q  [3];
  logic signed [31:0] hi_q  [3];
  logic [CW-1:0]      cnt_q [3];
  logic [CW-1:0]      off_q [3];
  logic [31:0]        blk_q [3];
  logic               clip_q;
  logic [33:0]        n_q;
  logic               neg_q;

  logic [33:0] p_ext;
  logic [33:0] n_d;
  logic [DIV_NW-1:0] n_ext;
  logic [DIV_NW-1:0] mag;
  logic [DIV_NW:0]   qs;
  logic [31:0]       qsat;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;

  assign p_ext = {{2{p_q[cmd_i.div_axis][31]}}, p_q[cmd_i.div_axis]};
  assign n_d   = cmd_i.div_hi ? (p_ext + {9'b0, trunc_q}) : (p_ext - {9'b0, trunc_q});
  assign n_ext = {n_q[33], n_q};
  assign mag   = n_q[33] ? (DIV_NW'(bsm1_q) - n_ext) : n_ext;

  assign qs = neg_q ? ((DIV_NW + 1)'(0) - {1'b0, div_quot}) : {1'b0, div_quot};

  always_comb begin
    if ($signed(qs) > $signed(36'h07FFFFFFF)) begin
      qsat = 32'h7FFFFFFF;
    end else if ($signed(qs) < $signed(36'hF80000000)) begin
      qsat = 32'h80000000;
    end else begin
      qsat = qs[31:0];
    end
  end

  // Hash over the current block
  logic [31:0] h_q;
  logic [31:0] h_coord;
  logic [31:0] h_prime;
  logic [31:0] h_prod;

  always_comb begin
    case (cmd_i.hash_step)
      STEP_X:  begin h_coord = blk_q[0]; h_prime = HASH_P0; end
      STEP_Y:  begin h_coord = blk_q[1]; h_prime = HASH_P1; end
      STEP_Z:  begin h_coord = blk_q[2]; h_prime = HASH_P2; end
      default: begin h_coord = blk_q[0]; h_prime = HASH_P0; end
    endcase
  end

  assign h_prod = h_coord * h_prime;

  // Divider: floor division of the range bounds
  assign div_start = cmd_i.div_start;
  assign div_num   = mag;
  assign div_den   = bs_q;

  ptbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Span clip and block walk
  logic [32:0]   diff [3];
  logic [CW-1:0] cnt_d [3];
  logic          clip_any;
  logic          last_block;

  always_comb begin
    clip_any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      diff[a] = {hi_q[a][31], hi_q[a]} - {lo_q[a][31], lo_q[a]};
      if (diff[a] > 33'(MAX_SPAN - 1)) begin
        cnt_d[a] = CW'(MAX_SPAN - 1);
        clip_any = 1'b1;
      end else begin
        cnt_d[a] = diff[a][CW-1:0];
      end
    end
  end

  assign last_block = (off_q[0] == cnt_q[0]) && (off_q[1] == cnt_q[1]) &&
                      (off_q[2] == cnt_q[2]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      p_q[0] <= point_x_i;
      p_q[1] <= point_y_i;
      p_q[2] <= point_z_i;
    end
    if (cmd_i.div_prep) begin
      n_q <= n_d;
    end
    if (cmd_i.div_start) begin
      neg_q <= n_q[33];
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_hi) begin
        hi_q[cmd_i.div_axis] <= qsat;
      end else begin
        lo_q[cmd_i.div_axis] <= qsat;
      end
    end
    if (cmd_i.span_calc) begin
      clip_q <= clip_any;
      for (int a = 0; a < 3; a++) begin
        cnt_q[a] <= cnt_d[a];
        off_q[a] <= '0;
        blk_q[a] <= lo_q[a];
      end
    end else if (cmd_i.next_block) begin
      if (off_q[2] != cnt_q[2]) begin
        off_q[2] <= off_q[2] + 1'b1;
        blk_q[2] <= blk_q[2] + 32'd1;
      end else begin
        off_q[2] <= '0;
        blk_q[2] <= lo_q[2];
        if (off_q[1] != cnt_q[1]) begin
          off_q[1] <= off_q[1] + 1'b1;
          blk_q[1] <= blk_q[1] + 32'd1;
        end else begin
          off_q[1] <= '0;
          blk_q[1] <= lo_q[1];
          off_q[0] <= off_q[0] + 1'b1;
          blk_q[0] <= blk_q[0] + 32'd1;
        end
      end
    end
    if (cmd_i.hash_en) begin
      h_q <= ((cmd_i.hash_step == STEP_X) ? 32'd0 : h_q) ^ h_prod;
    end
  end

  // Set memory: valid bit over the three block indexes
  logic [ROW_W-1:0] tbl_q [CAPACITY];
  logic [ROW_W-1:0] rdata_q;
  logic [AW-1:0]    slot_q;
  logic [AW-1:0]    probes_q;
  logic [AW-1:0]    sweep_q;
  logic [CNT_W-1:0] count_q;
  logic             new_q;
  logic             full_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             slot_empty;
  logic             slot_match;
  logic             slot_exhausted;

  assign slot_empty     = !rdata_q[ROW_W-1];
  assign slot_match     = rdata_q[95:0] == {blk_q[0], blk_q[1], blk_q[2]};
  assign slot_exhausted = probes_q == AW'(CAPACITY - 1);

  assign mem_we    = cmd_i.sweep_step || (cmd_i.probe_check && slot_empty);
  assign mem_waddr = cmd_i.sweep_step ? sweep_q : slot_q;
  assign mem_wdata = cmd_i.sweep_step ? '0 : {1'b1, blk_q[0], blk_q[1], blk_q[2]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_read) begin
      rdata_q <= tbl_q[slot_q];
    end
  end

  // Home slot: hash modulo a power-of-two capacity is its low bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_init) begin
      slot_q   <= h_q[AW-1:0];
      probes_q <= '0;
    end else if (cmd_i.probe_check) begin
      if (slot_empty) begin
        new_q  <= 1'b1;
        full_q <= 1'b0;
      end else if (slot_match) begin
        new_q  <= 1'b0;
        full_q <= 1'b0;
      end else if (slot_exhausted) begin
        new_q  <= 1'b0;
        full_q <= 1'b1;
      end else begin
        slot_q   <= (slot_q == AW'(CAPACITY - 1)) ? '0 : slot_q + 1'b1;
        probes_q <= probes_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.clear_start) begin
        sweep_q <= '0;
        count_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + 1'b1;
      end else if (cmd_i.probe_check && slot_empty) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Result register
  logic                out_valid_q;
  logic signed [31:0]  ox_q, oy_q, oz_q;
  logic                onew_q, ofull_q, oclip_q, olast_q;
  logic [STORED_W-1:0] ostored_q;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_clear) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_clear) begin
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      onew_q    <= 1'b0;
      ofull_q   <= 1'b0;
      oclip_q   <= 1'b0;
      ostored_q <= '0;
      olast_q   <= 1'b1;
    end else if (cmd_i.out_load) begin
      ox_q      <= blk_q[0];
      oy_q      <= blk_q[1];
      oz_q      <= blk_q[2];
      onew_q    <= new_q;
      ofull_q   <= full_q;
      oclip_q   <= clip_q;
      ostored_q <= count_q[STORED_W-1:0];
      olast_q   <= last_block;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_x_o       = ox_q;
  assign block_y_o       = oy_q;
  assign block_z_o       = oz_q;
  assign first_touch_o   = onew_q;
  assign set_full_o      = ofull_q;
  assign span_clipped_o  = oclip_q;
  assign stored_blocks_o = ostored_q;
  assign last_of_item_o  = olast_q;

  assign status_o.div_done   = div_done;
  assign status_o.probe_done = slot_empty || slot_match || slot_exhausted;
  assign status_o.last_block = last_block;
  assign status_o.sweep_done = sweep_q == AW'(CAPACITY - 1);
  assign status_o.out_free   = out_free;

endmodule

FILE: rtl/ptbs_ctrl.sv
// ----------------------------------------------------------------------------
// ptbs_ctrl
// Sequencer: range divisions, block walk, hash probe and set clearing.
// ----------------------------------------------------------------------------
module ptbs_ctrl
  import ptbs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_command_i,
  output logic         in_stall_o,
  input  ptbs_status_t status_i,
  output ptbs_cmd_t    cmd_o
);

  localparam logic [3:0] S_SWEEP      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_CLR_OUT    = 4'd2;
  localparam logic [3:0] S_DIV_PREP   = 4'd3;
  localparam logic [3:0] S_DIV_START  = 4'd4;
  localparam logic [3:0] S_DIV_WAIT   = 4'd5;
  localparam logic [3:0] S_DIV_STORE  = 4'd6;
  localparam logic [3:0] S_SPAN       = 4'd7;
  localparam logic [3:0] S_HASH       = 4'd8;
  localparam logic [3:0] S_PROBE_INIT = 4'd9;
  localparam logic [3:0] S_READ       = 4'd10;
  localparam logic [3:0] S_CHECK      = 4'd11;
  localparam logic [3:0] S_OUT        = 4'd12;

  logic [3:0] state_q, state_d;
  logic [2:0] dk_q, dk_d;
  logic [1:0] hs_q, hs_d;
  logic       accept;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    dk_d    = dk_q;
    hs_d    = hs_q;
    cmd_o   = '0;
    cmd_o.div_axis  = dk_q[2:1];
    cmd_o.div_hi    = dk_q[0];
    cmd_o.hash_step = hs_q;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_command_i == CMD_CLEAR) begin
            cmd_o.clear_start = 1'b1;
            state_d = S_CLR_OUT;
          end else begin
            cmd_o.load_item = 1'b1;
            dk_d    = '0;
            state_d = S_DIV_PREP;
          end
        end
      end
      S_CLR_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_clear = 1'b1;
          state_d = S_SWEEP;
        end
      end
      S_DIV_PREP: begin
        cmd_o.div_prep = 1'b1;
        state_d = S_DIV_START;
      end
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status_i.div_done) state_d = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        cmd_o.div_store = 1'b1;
        if (dk_q == 3'd5) begin
          state_d = S_SPAN;
        end else begin
          dk_d    = dk_q + 3'd1;
          state_d = S_DIV_PREP;
        end
      end
      S_SPAN: begin
        cmd_o.span_calc = 1'b1;
        hs_d    = STEP_X;
        state_d = S_HASH;
      end
      S_HASH: begin
        cmd_o.hash_en = 1'b1;
        if (hs_q == STEP_Z) begin
          state_d = S_PROBE_INIT;
        end else begin
          hs_d = hs_q + 2'd1;
        end
      end
      S_PROBE_INIT: begin
        cmd_o.probe_init = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.probe_check = 1'b1;
        state_d = status_i.probe_done ? S_OUT : S_READ;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.last_block) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_block = 1'b1;
            hs_d    = STEP_X;
            state_d = S_HASH;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      dk_q    <= '0;
      hs_q    <= '0;
    end else begin
      state_q <= state_d;
      dk_q    <= dk_d;
      hs_q    <= hs_d;
    end
  end

endmodule

FILE: rtl/point_touched_block_set.sv
// ----------------------------------------------------------------------------
// point_touched_block_set
// Touches every voxel block in a point's truncation band and tracks the set.
// ----------------------------------------------------------------------------
// One request carries a point in signed Q16.16 metres, or a clear command.
// A touch request yields one result per block in the box
// floor((p -/+ trunc) / (voxel edge * resolution)) on each axis, x outermost
// and z innermost, each axis cut to MAX_SPAN blocks. Each block is looked up
// in a CAPACITY-entry linear-probe hash set and inserted when absent; the
// result reports whether it was new, whether the set was full, and the fill.
// CAPACITY must be a power of two: the home slot is the low bits of the hash.
// A clear request returns one all-zero result with last_of_item set.
// The six range divisions go through one shared bit-serial divider, each
// with its setup and store steps. Each block then takes the hash multiply
// steps, a step to take the home slot from the hash, a read and a check
// per probe of the set memory, and a step to hand the result to the output
// register, plus any receiver stall. After reset and after every clear the
// set memory is swept once, one entry per cycle, and no request is taken
// during the sweep; configuration writes still are.
// A request is taken whenever the sequencer is idle, even while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module point_touched_block_set
  import ptbs_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  block_x_o,
  output logic signed [31:0]  block_y_o,
  output logic signed [31:0]  block_z_o,
  output logic                first_touch_o,
  output logic                set_full_o,
  output logic                span_clipped_o,
  output logic [STORED_W-1:0] stored_blocks_o,
  output logic                last_of_item_o
);

  ptbs_cmd_t    cmd;
  ptbs_status_t status;

  // Sequencer: accept the request, step the divider, walk blocks, probe, clear
  ptbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(command_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: hold config and point, compute ranges, hash, store, drive result
  ptbs_dp #(
    .CAPACITY(CAPACITY),
    .MAX_SPAN(MAX_SPAN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .block_x_o      (block_x_o),
    .block_y_o      (block_y_o),
    .block_z_o      (block_z_o),
    .first_touch_o  (first_touch_o),
    .set_full_o     (set_full_o),
    .span_clipped_o (span_clipped_o),
    .stored_blocks_o(stored_blocks_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
